// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WFPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wfpd check failed");

// Next-cycle implication.
`define WFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wfpd check failed");

`endif

// ===== hw/rtl/wfpd_pkg.sv =====
`timescale 1ns / 1ps
package wfpd_pkg;

	localparam int TICKS_PER_SECOND = 1000000;
	localparam int FRAC_BITS        = 8;
	localparam int ONE_CM           = 1 << FRAC_BITS;
	localparam int PD_SHIFT         = 8 + FRAC_BITS;

	localparam int ADC_W   = 10;
	localparam int TIME_W  = 32;
	localparam int DRV_W   = 8;
	localparam int MODE_W  = 3;
	localparam int DIST_W  = 19;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 4'd3;

	// drive modes
	localparam logic [MODE_W-1:0] MODE_FOLLOW   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RED_WAIT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RED_FWD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_APPROACH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TURN_L   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TURN_R   = 3'd5;

	// distance conversion: DIST_NUM / (adc + 5) - ONE_CM
	localparam int DIST_NUM  = 2914 << FRAC_BITS;
	localparam int DIST_Q_W  = $clog2(DIST_NUM + 1);
	localparam int ADC_OFS   = 5;

	// serial divider
	localparam int DIV_NW = 38;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);

	// thresholds on distances
	localparam logic signed [DIST_W-1:0] TH_C30   = DIST_W'(30 * ONE_CM);
	localparam logic signed [DIST_W-1:0] TH_C23   = DIST_W'(23 * ONE_CM);
	localparam logic signed [DIST_W-1:0] TH_C7    = DIST_W'(7 * ONE_CM);
	localparam logic signed [DIST_W-1:0] TH_TURN  = DIST_W'((13 * ONE_CM) / 2);
	localparam logic signed [DIST_W-1:0] TH_R25   = DIST_W'(25 * ONE_CM);
	localparam logic signed [DIST_W-1:0] TH_C15   = DIST_W'(15 * ONE_CM);
	localparam logic signed [DIST_W-1:0] TH_C16   = DIST_W'(16 * ONE_CM);

	typedef logic [ADC_W-1:0]         adc_t;
	typedef logic [TIME_W-1:0]        time_t;
	typedef logic [DRV_W-1:0]         drv_t;
	typedef logic [MODE_W-1:0]        mode_t;
	typedef logic signed [DIST_W-1:0] dist_t;

	// outcome of the mode machine for one sample
	typedef struct packed {
		logic  pd;
		mode_t mode;
		drv_t  left;
		drv_t  right;
	} dec_t;

endpackage

// ===== hw/rtl/wfpd_sample_if.sv =====
`timescale 1ns / 1ps
interface wfpd_sample_if;
	import wfpd_pkg::*;
	logic  valid;
	logic  ready;
	adc_t  right_adc;
	adc_t  center_adc;
	logic  red_seen;
	time_t sample_time;
	modport source(output valid, right_adc, center_adc, red_seen, sample_time, input ready);
	modport sink(input valid, right_adc, center_adc, red_seen, sample_time, output ready);
endinterface

// ===== hw/rtl/wfpd_result_if.sv =====
`timescale 1ns / 1ps
interface wfpd_result_if;
	import wfpd_pkg::*;
	logic  valid;
	logic  ready;
	drv_t  left_drive;
	drv_t  right_drive;
	mode_t drive_mode;
	dist_t wall_error;
	modport source(output valid, left_drive, right_drive, drive_mode, wall_error, input ready);
	modport sink(input valid, left_drive, right_drive, drive_mode, wall_error, output ready);
endinterface

// ===== hw/rtl/wfpd_cfg_if.sv =====
`timescale 1ns / 1ps
interface wfpd_cfg_if;
	import wfpd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wfpd_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Dividend is MSB-aligned by the caller.
module wfpd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wfpd_pkg::DIV_NW-1:0]   num,
	input  logic [wfpd_pkg::DIV_DW-1:0]   den,
	input  logic [wfpd_pkg::DIV_CW-1:0]   iters,
	output logic                          busy,
	output logic [wfpd_pkg::DIV_NW-1:0]   quo
);
	import wfpd_pkg::*;

	logic [DIV_NW-1:0] num_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = (cnt_q != '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= iters;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[DIV_NW-2:0], 1'b0};
			if (!diff[DIV_DW]) begin
				rem_q <= diff[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hw/rtl/wfpd_mode.sv =====
`timescale 1ns / 1ps
// Mode machine: picks the drive mode and fixed drive values, or flags a PD step.
module wfpd_mode (
	input  wfpd_pkg::mode_t mode_cur,
	input  logic            red,
	input  wfpd_pkg::dist_t rd,
	input  wfpd_pkg::dist_t cd,
	input  wfpd_pkg::drv_t  base,
	output wfpd_pkg::dec_t  dec
);
	import wfpd_pkg::*;

	logic [DRV_W:0] fast_sum;
	drv_t           fast;
	mode_t          stage;
	logic           done;

	// base*3/2 saturated
	assign fast_sum = {1'b0, base} + {2'b00, base[DRV_W-1:1]};
	assign fast     = fast_sum[DRV_W] ? {DRV_W{1'b1}} : fast_sum[DRV_W-1:0];

	always_comb begin
		dec.pd    = 1'b0;
		dec.mode  = mode_cur;
		dec.left  = '0;
		dec.right = '0;
		done      = 1'b0;
		stage     = MODE_FOLLOW;
		case (mode_cur)
			MODE_TURN_L: begin
				if (cd < TH_C15) begin
					dec.right = fast;
					done      = 1'b1;
				end
			end
			MODE_TURN_R: begin
				if (cd < TH_C16) begin
					dec.left = fast;
					done     = 1'b1;
				end
			end
			MODE_RED_WAIT, MODE_RED_FWD, MODE_APPROACH: begin
				stage = mode_cur;
			end
			default: begin
				stage = MODE_FOLLOW;
			end
		endcase

		if (!done && stage == MODE_FOLLOW) begin
			if (red) stage = (cd < TH_C30) ? MODE_RED_WAIT : MODE_RED_FWD;
			else     stage = MODE_APPROACH;
		end
		if (!done && stage == MODE_RED_WAIT) begin
			if (cd < TH_C30) begin
				dec.mode = MODE_RED_WAIT;
				done     = 1'b1;
			end else begin
				stage = MODE_RED_FWD;
			end
		end
		if (!done && stage == MODE_RED_FWD) begin
			if (red) begin
				dec.mode  = MODE_RED_FWD;
				dec.left  = base;
				dec.right = base;
				done      = 1'b1;
			end else begin
				stage = MODE_APPROACH;
			end
		end
		if (!done && stage == MODE_APPROACH) begin
			if (cd < TH_C23 && cd > TH_C7) begin
				dec.mode  = MODE_APPROACH;
				dec.left  = base;
				dec.right = base;
				done      = 1'b1;
			end
		end
		if (!done && cd <= TH_TURN) begin
			if (rd < TH_R25) begin
				dec.mode  = MODE_TURN_L;
				dec.right = fast;
			end else begin
				dec.mode = MODE_TURN_R;
				dec.left = fast;
			end
			done = 1'b1;
		end
		if (!done) begin
			dec.pd   = 1'b1;
			dec.mode = MODE_FOLLOW;
		end
	end

endmodule

// ===== hw/rtl/wall_follow_pd_steering.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Word
// sample   in   valid/ready    right_adc, center_adc, red_seen, sample_time
// result   out  valid/ready    left_drive, right_drive, drive_mode, wall_error
// cfg      in   valid/ready    index, data (ready always high)
//
// One sample at a time. Both distances come from two restoring dividers run side
// by side, one bit a cycle, started on acceptance; S_DEC follows once both finish.
// A sample settled by the mode machine goes from S_DEC straight to S_OUT. A PD step
// reuses the right divider for the rate term over 38 bits, through S_MUL1, S_PDDIV,
// S_MUL2 and S_ADD; the division is skipped on a zero dt.
// Reset restores register defaults, mode follow, zero last error and time.
// A waiting result sits in the output register; the next word is still taken and
// worked through, then waits in S_OUT until that register frees.
module wall_follow_pd_steering (
	input  logic           clk,
	input  logic           arst_n,
	wfpd_sample_if.sink    sample,
	wfpd_result_if.source  result,
	wfpd_cfg_if.sink       cfg
);
	import wfpd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIST  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_MUL1  = 3'd3;
	localparam logic [2:0] S_PDDIV = 3'd4;
	localparam logic [2:0] S_MUL2  = 3'd5;
	localparam logic [2:0] S_ADD   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam int SUM_W = 54;

	// config registers
	drv_t        base_q;
	logic [15:0] target_q;
	logic [11:0] prop_q;
	logic [11:0] deriv_q;

	// control state
	logic [2:0]  state_q;
	mode_t       mode_q;
	dist_t       last_err_q;
	time_t       last_time_q;
	logic        outv_q;

	// per-sample payload
	logic                red_q;
	time_t               time_q;
	dist_t               rd_q;
	dist_t               cd_q;
	dist_t               err_q;
	dec_t                dec_q;
	logic [DIST_W:0]     mag_q;
	logic                neg_q;
	logic                dtz_q;
	time_t               dt_q;
	logic signed [DIV_NW:0] dv_q;
	logic signed [31:0]  p1_q;
	logic signed [51:0]  p2_q;

	// output register
	drv_t  out_left_q;
	drv_t  out_right_q;
	mode_t out_mode_q;
	dist_t out_err_q;

	// dividers
	logic              acc;
	logic              start_a;
	logic              start_b;
	logic [DIV_NW-1:0] num_a;
	logic [DIV_DW-1:0] den_a;
	logic [DIV_CW-1:0] iters_a;
	logic              busy_a;
	logic              busy_b;
	logic [DIV_NW-1:0] quo_a;
	logic [DIV_NW-1:0] quo_b;
	logic [DIV_NW-1:0] dist_num;

	dec_t dec_w;

	logic signed [DIST_Q_W:0]  rd_w;
	logic signed [DIST_Q_W:0]  cd_w;
	logic signed [DIST_W:0]    err_w;
	logic signed [DIST_W:0]    diff_w;
	logic [DIST_W:0]           mag_w;
	logic [DIST_W+TPS_W:0]     prod_w;
	logic signed [SUM_W-1:0]   adj_w;
	logic signed [SUM_W-1:0]   bfix_w;
	logic signed [SUM_W-1:0]   sl_w;
	logic signed [SUM_W-1:0]   sr_w;
	drv_t                      left_w;
	drv_t                      right_w;
	logic                      load_out;

	assign acc          = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;

	// dividend left-aligned so only DIST_Q_W steps are needed
	assign dist_num = DIV_NW'(DIST_NUM) << (DIV_NW - DIST_Q_W);

	assign start_a = acc || (state_q == S_MUL1 && dt_q != '0);
	assign start_b = acc;
	always_comb begin
		if (state_q == S_IDLE) begin
			num_a   = dist_num;
			den_a   = DIV_DW'(sample.right_adc) + DIV_DW'(ADC_OFS);
			iters_a = DIV_CW'(DIST_Q_W);
		end else begin
			num_a   = prod_w[DIV_NW-1:0];
			den_a   = dt_q;
			iters_a = DIV_CW'(DIV_NW);
		end
	end

	wfpd_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_a),
		.num    (num_a),
		.den    (den_a),
		.iters  (iters_a),
		.busy   (busy_a),
		.quo    (quo_a)
	);

	wfpd_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_b),
		.num    (dist_num),
		.den    (DIV_DW'(sample.center_adc) + DIV_DW'(ADC_OFS)),
		.iters  (DIV_CW'(DIST_Q_W)),
		.busy   (busy_b),
		.quo    (quo_b)
	);

	wfpd_mode u_mode (
		.mode_cur (mode_q),
		.red      (red_q),
		.rd       (rd_q),
		.cd       (cd_q),
		.base     (base_q),
		.dec      (dec_w)
	);

	// distances and wall error
	assign rd_w  = $signed({1'b0, quo_a[DIST_Q_W-1:0]}) - $signed((DIST_Q_W+1)'(ONE_CM));
	assign cd_w  = $signed({1'b0, quo_b[DIST_Q_W-1:0]}) - $signed((DIST_Q_W+1)'(ONE_CM));
	assign err_w = $signed({{(DIST_W-16){1'b0}}, target_q}) - $signed({rd_q[DIST_W-1], rd_q});

	// rate term numerator, sign-magnitude; magnitude registered at decode
	assign diff_w = err_w - $signed({last_err_q[DIST_W-1], last_err_q});
	assign mag_w  = diff_w[DIST_W] ? $unsigned(-diff_w) : $unsigned(diff_w);
	assign prod_w = mag_q * TPS_W'(TICKS_PER_SECOND);

	// PD sum, 8+FRAC_BITS fraction bits
	assign adj_w  = SUM_W'(p1_q) + SUM_W'(p2_q);
	assign bfix_w = $signed({{(SUM_W-DRV_W-PD_SHIFT){1'b0}}, base_q, {PD_SHIFT{1'b0}}});
	assign sl_w   = bfix_w - adj_w;
	assign sr_w   = bfix_w + adj_w;

	always_comb begin
		if (sl_w[SUM_W-1])                         left_w = '0;
		else if (|sl_w[SUM_W-2:PD_SHIFT+DRV_W])    left_w = {DRV_W{1'b1}};
		else                                       left_w = sl_w[PD_SHIFT+DRV_W-1:PD_SHIFT];
		if (sr_w[SUM_W-1])                         right_w = '0;
		else if (|sr_w[SUM_W-2:PD_SHIFT+DRV_W])    right_w = {DRV_W{1'b1}};
		else                                       right_w = sr_w[PD_SHIFT+DRV_W-1:PD_SHIFT];
	end

	assign load_out = (state_q == S_OUT) && (!outv_q || result.ready);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= 8'd35;
			target_q <= 16'd1280;
			prop_q   <= 12'd256;
			deriv_q  <= 12'd154;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BASE_SPEED: base_q   <= cfg.data[DRV_W-1:0];
				CFG_TARGET:     target_q <= cfg.data;
				CFG_PROP_GAIN:  prop_q   <= cfg.data[11:0];
				CFG_DERIV_GAIN: deriv_q  <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// sequencer and state kept between samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_FOLLOW;
			last_err_q  <= '0;
			last_time_q <= '0;
			outv_q      <= 1'b0;
		end else begin
			if (load_out) outv_q <= 1'b1;
			else if (result.valid && result.ready) outv_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (acc) state_q <= S_DIST;
				S_DIST:  if (!busy_a && !busy_b) state_q <= S_DEC;
				S_DEC:   state_q <= dec_w.pd ? S_MUL1 : S_OUT;
				S_MUL1:  state_q <= S_PDDIV;
				S_PDDIV: if (!busy_a) state_q <= S_MUL2;
				S_MUL2:  state_q <= S_ADD;
				S_ADD: begin
					last_err_q  <= err_q;
					last_time_q <= time_q;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						mode_q  <= dec_q.mode;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc) begin
			red_q  <= sample.red_seen;
			time_q <= sample.sample_time;
		end
		if (state_q == S_DIST) begin
			rd_q <= rd_w[DIST_W-1:0];
			cd_q <= cd_w[DIST_W-1:0];
		end
		if (state_q == S_DEC) begin
			dec_q  <= dec_w;
			err_q  <= err_w[DIST_W-1:0];
			mag_q  <= mag_w;
			neg_q  <= diff_w[DIST_W];
		end
		if (state_q == S_MUL1 || state_q == S_DEC) begin
			dt_q <= time_q - last_time_q;
		end
		if (state_q == S_MUL1) begin
			dtz_q <= (dt_q == '0);
		end
		if (state_q == S_PDDIV) begin
			if (dtz_q)       dv_q <= '0;
			else if (neg_q)  dv_q <= -$signed({1'b0, quo_a});
			else             dv_q <= $signed({1'b0, quo_a});
		end
		if (state_q == S_MUL2) begin
			p1_q <= err_q * $signed({1'b0, prop_q});
			p2_q <= dv_q * $signed({1'b0, deriv_q});
		end
		if (state_q == S_ADD) begin
			dec_q.left  <= left_w;
			dec_q.right <= right_w;
		end
		if (load_out) begin
			out_left_q  <= dec_q.left;
			out_right_q <= dec_q.right;
			out_mode_q  <= dec_q.mode;
			out_err_q   <= err_q;
		end
	end

	assign result.valid       = outv_q;
	assign result.left_drive  = out_left_q;
	assign result.right_drive = out_right_q;
	assign result.drive_mode  = out_mode_q;
	assign result.wall_error  = out_err_q;

endmodule

// ===== hw/rtl/wfpd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wfpd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input wfpd_pkg::drv_t        left_drive,
	input wfpd_pkg::drv_t        right_drive,
	input wfpd_pkg::mode_t       drive_mode,
	input wfpd_pkg::dist_t       wall_error
);
	import wfpd_pkg::*;

	`WFPD_ASSERT_SAME(a_wait_stops, clk, arst_n, out_valid && drive_mode == MODE_RED_WAIT, left_drive == '0 && right_drive == '0)
	`WFPD_ASSERT_SAME(a_turn_one_side, clk, arst_n, out_valid && (drive_mode == MODE_TURN_L || drive_mode == MODE_TURN_R), (drive_mode == MODE_TURN_L) ? (left_drive == '0) : (right_drive == '0))
	`WFPD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`WFPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(wall_error))

endmodule

bind wall_follow_pd_steering wfpd_checker u_wfpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.left_drive  (result.left_drive),
	.right_drive (result.right_drive),
	.drive_mode  (result.drive_mode),
	.wall_error  (result.wall_error)
);
